// ===== hdl/pdt_pkg.sv =====
// Shared constants and controller/datapath interface types for the protection domain table.
`default_nettype none

package pdt_pkg;

  localparam int NUM_DOMAINS  = 128;
  localparam int NUM_SEGMENTS = 64;

  localparam int IDX_W    = $clog2(NUM_DOMAINS);
  localparam int SEG_W    = $clog2(NUM_SEGMENTS);
  localparam int CMD_W    = 2;
  localparam int STS_W    = 2;
  localparam int ID_W     = 32;
  localparam int HALF_W   = 16;
  localparam int CNT_W    = 16;
  localparam int GEN_W    = 16;
  localparam int SEG_IN_W = 6;
  localparam int RIGHTS_W = 4;
  localparam int RIGHTS_AW    = IDX_W + SEG_W;
  localparam int RIGHTS_DEPTH = NUM_DOMAINS * (1 << SEG_W);

  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RETAIN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RIGHTS  = 2'd3;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_BOGUS = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic alloc;
    logic clear_step;
    logic exec;
    logic full;
    logic out_load;
  } pdt_cmd_t;

  typedef struct packed {
    logic is_create;
    logic free_hit;
    logic scan_last;
    logic clear_last;
    logic out_busy;
  } pdt_sts_t;

endpackage

`default_nettype wire

// ===== hdl/pdt_ctrl.sv =====
// Sequencer for the protection domain table: decode, free-slot scan, rights clear, result.
`default_nettype none

module pdt_ctrl
  import pdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pdt_sts_t sts,
  output pdt_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_ALLOC,
    S_CLEAR,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = sts.is_create ? S_SEARCH : S_EXEC;
      end
      S_SEARCH: begin
        if (sts.free_hit) begin
          state_nxt = S_ALLOC;
        end else if (sts.scan_last) begin
          cmd.full  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_DONE;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pdt_datapath.sv =====
// Slot tables, count/generation/rights memories, scan pointer and result register.
`default_nettype none

module pdt_datapath
  import pdt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pdt_cmd_t            cmd,
  output pdt_sts_t                 sts,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [ID_W-1:0]     in_domain_id,
  input  wire logic [SEG_IN_W-1:0] in_segment_id,
  input  wire logic [RIGHTS_W-1:0] in_rights_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STS_W-1:0]         out_status,
  output logic [ID_W-1:0]          out_new_domain_id
);

  localparam int SEG_CMP_W = SEG_W + SEG_IN_W;

  // slot flags and memories
  logic [NUM_DOMAINS-1:0] in_use_r;
  logic [NUM_DOMAINS-1:0] gen_vld_r;
  logic [GEN_W-1:0]       gen_mem [NUM_DOMAINS];
  logic [CNT_W-1:0]       cnt_mem [NUM_DOMAINS];
  logic [RIGHTS_W-1:0]    rights_mem [RIGHTS_DEPTH];

  logic [IDX_W-1:0]    hint_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [HALF_W-1:0]   dom_r;
  logic [SEG_IN_W-1:0] seg_r;
  logic [RIGHTS_W-1:0] val_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [IDX_W-1:0]    scan_cnt_r;
  logic [SEG_W-1:0]    clr_cnt_r;
  logic [GEN_W-1:0]    gen_rd_r;
  logic                gen_rd_vld_r;
  logic [CNT_W-1:0]    cnt_rd_r;
  logic [STS_W-1:0]    res_status_r;
  logic [ID_W-1:0]     res_id_r;
  logic                out_valid_r;
  logic [STS_W-1:0]    out_status_r;
  logic [ID_W-1:0]     out_id_r;

  logic [IDX_W-1:0]     idx;
  logic                 dom_ok;
  logic [IDX_W-1:0]     scan_nxt;
  logic [GEN_W-1:0]     gen_new;
  logic [CNT_W-1:0]     cnt_dec;
  logic [SEG_CMP_W-1:0] seg_wide;
  logic                 seg_ok;

  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_wa;
  logic [CNT_W-1:0]     cnt_wd;
  logic                 rights_we;
  logic [RIGHTS_AW-1:0] rights_wa;
  logic [RIGHTS_W-1:0]  rights_wd;

  assign idx      = dom_r[IDX_W-1:0];
  assign dom_ok   = (dom_r < HALF_W'(NUM_DOMAINS)) && in_use_r[idx];
  assign scan_nxt = (scan_idx_r == IDX_W'(NUM_DOMAINS - 1)) ? '0 : scan_idx_r + 1'b1;
  assign gen_new  = (gen_rd_vld_r ? gen_rd_r : '0) + 1'b1;
  assign cnt_dec  = (cnt_rd_r == '0) ? '0 : cnt_rd_r - 1'b1;
  assign seg_wide = SEG_CMP_W'(seg_r);
  assign seg_ok   = seg_wide < SEG_CMP_W'(NUM_SEGMENTS);

  assign sts.is_create  = (cmd_r == CMD_CREATE);
  assign sts.free_hit   = !in_use_r[scan_idx_r];
  assign sts.scan_last  = (scan_cnt_r == IDX_W'(NUM_DOMAINS - 1));
  assign sts.clear_last = (clr_cnt_r == SEG_W'(NUM_SEGMENTS - 1));
  assign sts.out_busy   = out_valid_r && out_stall;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_wa    = idx;
    cnt_wd    = '0;
    rights_we = 1'b0;
    rights_wa = {idx, seg_wide[SEG_W-1:0]};
    rights_wd = val_r;
    if (cmd.alloc) begin
      cnt_we = 1'b1;
      cnt_wa = scan_idx_r;
    end else if (cmd.clear_step) begin
      rights_we = 1'b1;
      rights_wa = {scan_idx_r, clr_cnt_r};
      rights_wd = '0;
    end else if (cmd.exec && dom_ok) begin
      case (cmd_r)
        CMD_RETAIN: begin
          cnt_we = 1'b1;
          cnt_wd = cnt_rd_r + 1'b1;
        end
        CMD_RELEASE: begin
          cnt_we = 1'b1;
          cnt_wd = cnt_dec;
        end
        CMD_RIGHTS: begin
          rights_we = seg_ok;
        end
        default: begin
          cnt_we = 1'b0;
        end
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    gen_rd_r <= gen_mem[scan_idx_r];
    cnt_rd_r <= cnt_mem[idx];
    if (cmd.alloc) begin
      gen_mem[scan_idx_r] <= gen_new;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (rights_we) begin
      rights_mem[rights_wa] <= rights_wd;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r     <= '0;
      gen_vld_r    <= '0;
      hint_r       <= '0;
      out_valid_r  <= 1'b0;
      gen_rd_vld_r <= 1'b0;
    end else begin
      gen_rd_vld_r <= gen_vld_r[scan_idx_r];
      if (cmd.alloc) begin
        in_use_r[scan_idx_r]  <= 1'b1;
        gen_vld_r[scan_idx_r] <= 1'b1;
        hint_r                <= scan_nxt;
      end
      if (cmd.exec && dom_ok && (cmd_r == CMD_RELEASE) && (cnt_dec == '0)) begin
        in_use_r[idx] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat capture, scan pointers, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_cmd;
      dom_r      <= in_domain_id[HALF_W-1:0];
      seg_r      <= in_segment_id;
      val_r      <= in_rights_value;
      scan_idx_r <= hint_r;
      scan_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_nxt;
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    if (cmd.alloc) begin
      clr_cnt_r    <= '0;
      res_status_r <= ST_OK;
      res_id_r     <= {gen_new, HALF_W'(scan_idx_r)};
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
    if (cmd.full) begin
      res_status_r <= ST_FULL;
      res_id_r     <= '0;
    end
    if (cmd.exec) begin
      res_status_r <= dom_ok ? ST_OK : ST_BOGUS;
      res_id_r     <= '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_domain_id = out_id_r;

endmodule

`default_nettype wire

// ===== hdl/protection_domain_table.sv =====
// Top level of the protection domain table: controller plus datapath.
`default_nettype none

// Handle table of NUM_DOMAINS protection domains. Commands: create (0), retain (1),
// release (2), set rights (3). Create returns {generation, index}; others return id 0.
// One command is processed at a time; in_stall is high from acceptance until the
// result is placed in the output register, which can hold one finished beat while
// the next command is taken. The next command can be accepted in the cycle in which the
// result appears. Retain, release and set rights pass through the read and exec states;
// create scans one slot per cycle from the round-robin hint past used slots, allocates
// the free slot, then clears the new slot's rights nibbles one per cycle through the
// single write port of the rights memory. A create on a full table reports status 2
// after scanning all NUM_DOMAINS slots. A stalled result register holds the controller
// in its done state until it drains. Rights are write-only and never read back.
module protection_domain_table
  import pdt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [ID_W-1:0]     in_domain_id,
  input  wire logic [SEG_IN_W-1:0] in_segment_id,
  input  wire logic [RIGHTS_W-1:0] in_rights_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STS_W-1:0]         out_status,
  output logic [ID_W-1:0]          out_new_domain_id
);

  pdt_cmd_t cmd;
  pdt_sts_t sts;

  pdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_domain_id      (in_domain_id),
    .in_segment_id     (in_segment_id),
    .in_rights_value   (in_rights_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_new_domain_id (out_new_domain_id)
  );

endmodule

`default_nettype wire

// ===== hdl/pdt_checker.sv =====
// Port-level checks for the protection domain table and their bind.
`default_nettype none

module pdt_checker
  import pdt_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STS_W-1:0]    out_status,
  input wire logic [ID_W-1:0]     out_new_domain_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_new_domain_id))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while a command is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_BOGUS || out_status == ST_FULL)
    else $error("undefined status code");

  a_err_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_new_domain_id == '0)
    else $error("error beat carries a nonzero id");

  a_id_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_new_domain_id[HALF_W-1:0] < HALF_W'(NUM_DOMAINS))
    else $error("returned id has an out-of-range index");

endmodule

bind protection_domain_table pdt_checker u_pdt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_new_domain_id (out_new_domain_id)
);

`default_nettype wire
